// ===== hw/rtl/rbp_pkg.sv =====
// Shared constants, codes and types for the retained block pool.
package rbp_pkg;

   // Pool geometry
   localparam int POOL_ENTRIES = 4;
   localparam int IDX_W        = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int CNT_W        = $clog2(POOL_ENTRIES + 1);

   // Field widths
   localparam int BASE_W = 48;
   localparam int SIZE_W = 32;
   localparam int HELD_W = 33;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   // Register reset values
   localparam logic [SIZE_W-1:0] MIN_RETAIN_RESET = SIZE_W'(256 * 1024);
   localparam logic [SIZE_W-1:0] MAX_BYTES_RESET  = SIZE_W'(32 * 1024 * 1024);

   // Register index, taken from paddr[2]
   typedef enum logic {
      REG_MIN_RETAIN = 1'b0,
      REG_MAX_BYTES  = 1'b1
   } reg_index_type;

   // Request kind
   typedef enum logic {
      REQ_TAKE = 1'b0,
      REQ_GIVE = 1'b1
   } req_kind_type;

   // Result codes
   typedef enum logic [2:0] {
      OUT_HIT       = 3'd0,
      OUT_BELOW_MIN = 3'd1,
      OUT_NO_FIT    = 3'd2,
      OUT_RETAINED  = 3'd3,
      OUT_REL_SMALL = 3'd4,
      OUT_REL_FULL  = 3'd5
   } outcome_type;

   // Search token handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic [SIZE_W-1:0] request;
      logic              have;
      logic [SIZE_W-1:0] best_size;
      logic [BASE_W-1:0] best_base;
      logic [IDX_W-1:0]  pick;
      logic [SIZE_W-1:0] last_size;
      logic [BASE_W-1:0] last_base;
   } token_type;

   // Entry write into one cell
   typedef struct packed {
      logic              en;
      logic [BASE_W-1:0] base;
      logic [SIZE_W-1:0] size;
   } cell_wr_type;

endpackage

// ===== hw/rtl/rbp_cell.sv =====
// One pool slot: holds an entry and refines the passing best-fit token.
module rbp_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [rbp_pkg::IDX_W-1:0] cell_idx,
   input  logic [rbp_pkg::CNT_W-1:0] entry_count,
   input  rbp_pkg::token_type       token_in,
   input  rbp_pkg::cell_wr_type     wr,
   output rbp_pkg::token_type       token_out
);
   import rbp_pkg::*;

   logic [BASE_W-1:0] entry_base_ff;
   logic [SIZE_W-1:0] entry_size_ff;
   token_type         token_ff;
   token_type         token_in_next;
   logic              active;
   logic              is_last;
   logic              fits;
   logic              better;

   // Slot is live below the fill count; last live slot feeds compaction
   always_comb begin
      active  = CNT_W'(cell_idx) < entry_count;
      is_last = (CNT_W'(cell_idx) + CNT_W'(1)) == entry_count;
      fits    = entry_size_ff >= token_in.request;
      better  = !token_in.have || (entry_size_ff < token_in.best_size);
      token_in_next = token_in;
      // strict compare keeps the lower index on a tie
      if (active && fits && better) begin
         token_in_next.have      = 1'b1;
         token_in_next.best_size = entry_size_ff;
         token_in_next.best_base = entry_base_ff;
         token_in_next.pick      = cell_idx;
      end
      if (is_last) begin
         token_in_next.last_size = entry_size_ff;
         token_in_next.last_base = entry_base_ff;
      end
   end

   // Token register toward the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
      end else begin
         token_ff <= token_in_next;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_base_ff <= wr.base;
         entry_size_ff <= wr.size;
      end
   end

   assign token_out = token_ff;

endmodule

// ===== hw/rtl/retained_block_pool.sv =====
// Top level of the retained block pool: control, CSRs and the cell chain.
//
//   channel  | ports                                         | beat accepted
//   ---------+-----------------------------------------------+--------------------------
//   request  | start, busy, req_type, req_block_base/size    | start && !busy
//   result   | rsp_strobe, rsp_outcome, rsp_found_base/cap   | every cycle rsp_strobe high
//   config   | psel, penable, pwrite, paddr, pwdata, prdata  | psel && penable && pwrite
//
// A give, or a take below the minimum, resolves in the accept cycle; its result
// shows in the next cycle and a new beat may follow at once.
// A take that is scanned walks its token through POOL_ENTRIES cells, one per
// cycle, then commits; busy is high while the token is in the chain, and the
// result is registered at the commit. The cell chain length sets how long the scan lasts.
// Reset clears the fill count, byte total and control; entries are not cleared.
// The result side has no backpressure.
module retained_block_pool (
   input  logic                             clock,
   input  logic                             reset,
   // request
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [rbp_pkg::BASE_W-1:0]       req_block_base,
   input  logic [rbp_pkg::SIZE_W-1:0]       req_block_size,
   // result
   output logic                             rsp_strobe,
   output logic [2:0]                       rsp_outcome,
   output logic [rbp_pkg::BASE_W-1:0]       rsp_found_base,
   output logic [rbp_pkg::SIZE_W-1:0]       rsp_found_capacity,
   // configuration
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rbp_pkg::ADDR_W-1:0]       paddr,
   input  logic [rbp_pkg::DATA_W-1:0]       pwdata,
   output logic [rbp_pkg::DATA_W-1:0]       prdata,
   output logic                             pready
);
   import rbp_pkg::*;

   logic [SIZE_W-1:0] min_retain_ff;
   logic [SIZE_W-1:0] max_bytes_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [HELD_W-1:0] held_ff;
   logic [HELD_W-1:0] held_in;
   logic              busy_ff;
   logic              busy_in;

   logic              rsp_strobe_ff;
   logic              rsp_strobe_in;
   outcome_type       rsp_outcome_ff;
   outcome_type       rsp_outcome_in;
   logic [BASE_W-1:0] rsp_base_ff;
   logic [BASE_W-1:0] rsp_base_in;
   logic [SIZE_W-1:0] rsp_cap_ff;
   logic [SIZE_W-1:0] rsp_cap_in;

   logic              accept;
   logic              is_give;
   logic              below_min;
   logic              pool_full;
   logic              over_budget;
   logic              give_ok;
   logic              scan_go;
   logic              commit_hit;
   logic              cfg_wr;
   reg_index_type     cfg_idx;

   token_type         head_token;
   token_type         tail_token;
   token_type         chain [POOL_ENTRIES];
   cell_wr_type       cell_wr [POOL_ENTRIES];
   logic [POOL_ENTRIES-1:0] chain_valid;

   // Config port
   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = reg_index_type'(paddr[2]);

   always_comb begin
      case (cfg_idx)
         REG_MIN_RETAIN: prdata = min_retain_ff;
         REG_MAX_BYTES:  prdata = max_bytes_ff;
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_retain_ff <= MIN_RETAIN_RESET;
         max_bytes_ff  <= MAX_BYTES_RESET;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_MIN_RETAIN: min_retain_ff <= pwdata;
            REG_MAX_BYTES:  max_bytes_ff  <= pwdata;
            default:        min_retain_ff <= min_retain_ff;
         endcase
      end
   end

   // Request decode
   assign busy        = busy_ff;
   assign accept      = start && !busy_ff;
   assign is_give     = req_kind_type'(req_type) == REQ_GIVE;
   assign below_min   = req_block_size < min_retain_ff;
   assign pool_full   = count_ff == CNT_W'(POOL_ENTRIES);
   assign over_budget = ({1'b0, held_ff} + (HELD_W + 1)'(req_block_size))
                        > (HELD_W + 1)'(max_bytes_ff);
   assign give_ok     = accept && is_give && !below_min && !pool_full && !over_budget;
   assign scan_go     = accept && !is_give && !below_min;
   assign commit_hit  = tail_token.valid && tail_token.have;

   // Token entering the first cell
   always_comb begin
      head_token           = '0;
      head_token.valid     = scan_go;
      head_token.request   = req_block_size;
   end

   // Cell chain
   for (genvar k = 0; k < POOL_ENTRIES; k++) begin : g_cell
      always_comb begin
         cell_wr[k].en   = (give_ok && (count_ff == CNT_W'(k)))
                        || (commit_hit && (tail_token.pick == IDX_W'(k)));
         cell_wr[k].base = give_ok ? req_block_base : tail_token.last_base;
         cell_wr[k].size = give_ok ? req_block_size : tail_token.last_size;
      end

      rbp_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (IDX_W'(k)),
         .entry_count (count_ff),
         .token_in    ((k == 0) ? head_token : chain[(k == 0) ? 0 : k - 1]),
         .wr          (cell_wr[k]),
         .token_out   (chain[k])
      );

      assign chain_valid[k] = chain[k].valid;
   end

   assign tail_token = chain[POOL_ENTRIES-1];

   // Control and pool totals
   always_comb begin
      busy_in        = busy_ff;
      count_in       = count_ff;
      held_in        = held_ff;
      rsp_strobe_in  = 1'b0;
      rsp_outcome_in = OUT_HIT;
      rsp_base_in    = '0;
      rsp_cap_in     = '0;
      if (tail_token.valid) begin
         // scan finished: commit hit or report no fit
         busy_in       = 1'b0;
         rsp_strobe_in = 1'b1;
         if (tail_token.have) begin
            count_in       = count_ff - CNT_W'(1);
            held_in        = (held_ff >= HELD_W'(tail_token.best_size))
                           ? held_ff - HELD_W'(tail_token.best_size) : '0;
            rsp_outcome_in = OUT_HIT;
            rsp_base_in    = tail_token.best_base;
            rsp_cap_in     = tail_token.best_size;
         end else begin
            rsp_outcome_in = OUT_NO_FIT;
         end
      end else if (accept) begin
         if (is_give) begin
            rsp_strobe_in = 1'b1;
            if (below_min) begin
               rsp_outcome_in = OUT_REL_SMALL;
            end else if (pool_full || over_budget) begin
               rsp_outcome_in = OUT_REL_FULL;
            end else begin
               rsp_outcome_in = OUT_RETAINED;
               count_in       = count_ff + CNT_W'(1);
               held_in        = held_ff + HELD_W'(req_block_size);
            end
         end else if (below_min) begin
            rsp_strobe_in  = 1'b1;
            rsp_outcome_in = OUT_BELOW_MIN;
         end else begin
            busy_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         count_ff      <= '0;
         held_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         count_ff      <= count_in;
         held_ff       <= held_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_base_ff    <= rsp_base_in;
      rsp_cap_ff     <= rsp_cap_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_outcome        = rsp_outcome_ff;
   assign rsp_found_base     = rsp_base_ff;
   assign rsp_found_capacity = rsp_cap_ff;

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(POOL_ENTRIES))
      else $error("fill count beyond pool size");

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_valid))
      else $error("more than one search token in the chain");

   a_token_busy: assert property (@(posedge clock) disable iff (reset)
      (chain_valid != '0) |-> busy_ff)
      else $error("search token in flight while not busy");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_outcome_ff != OUT_HIT))
      |-> (rsp_base_ff == '0 && rsp_cap_ff == '0))
      else $error("non-hit result carries a block");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the retained block pool: best-fit takes, gives and CSR settings.
`timescale 1ns / 1ps

module tb;
   import rbp_pkg::*;

   // One expected beat on the result side
   typedef struct packed {
      outcome_type       outcome;
      logic [BASE_W-1:0] base;
      logic [SIZE_W-1:0] cap;
   } pool_result_type;

   // Mirror of the pool plus the queue of results still owed by the block
   class pool_scoreboard;
      bit [SIZE_W-1:0] min_size;
      bit [SIZE_W-1:0] byte_budget;
      bit [BASE_W-1:0] held_base [POOL_ENTRIES];
      bit [SIZE_W-1:0] held_size [POOL_ENTRIES];
      int              held_count;
      bit [HELD_W-1:0] held_total;
      pool_result_type owed_results [$];
      int              errors;
      int              requests;
      int              tally [8];

      function new();
         min_size    = 32'd262144;
         byte_budget = 32'd33554432;
         held_count  = 0;
         held_total  = '0;
         errors      = 0;
         requests    = 0;
         foreach (tally[i]) tally[i] = 0;
      endfunction

      function void write_reg(reg_index_type idx, bit [DATA_W-1:0] value);
         if (idx == REG_MIN_RETAIN) min_size = value;
         else byte_budget = value;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      // size of a random held block, or the floor when nothing is held
      function bit [SIZE_W-1:0] some_held_size();
         if (held_count == 0) return min_size;
         return held_size[$urandom_range(held_count - 1)];
      endfunction

      // Work out the result of an accepted request and update the pool
      function void note_request(req_kind_type kind, bit [BASE_W-1:0] base,
                                 bit [SIZE_W-1:0] size);
         pool_result_type r;
         int              pick;
         bit [HELD_W:0]   sum;
         r.outcome = OUT_HIT;
         r.base    = '0;
         r.cap     = '0;
         pick      = -1;
         requests++;
         if (kind == REQ_TAKE) begin
            if (size < min_size) begin
               r.outcome = OUT_BELOW_MIN;
            end else begin
               // smallest covering block, lowest index on a tie
               for (int i = 0; i < held_count; i++)
                  if (held_size[i] >= size && (pick < 0 || held_size[i] < held_size[pick]))
                     pick = i;
               if (pick < 0) begin
                  r.outcome = OUT_NO_FIT;
               end else begin
                  r.base = held_base[pick];
                  r.cap  = held_size[pick];
                  held_count--;
                  held_base[pick] = held_base[held_count];
                  held_size[pick] = held_size[held_count];
                  held_total = (held_total >= HELD_W'(r.cap)) ?
                               held_total - HELD_W'(r.cap) : '0;
               end
            end
         end else begin
            sum = {1'b0, held_total} + (HELD_W + 1)'(size);
            if (size < min_size) begin
               r.outcome = OUT_REL_SMALL;
            end else if (held_count >= POOL_ENTRIES ||
                         sum > (HELD_W + 1)'(byte_budget)) begin
               r.outcome = OUT_REL_FULL;
            end else begin
               r.outcome = OUT_RETAINED;
               held_base[held_count] = base;
               held_size[held_count] = size;
               held_count++;
               held_total = sum[HELD_W-1:0];
            end
         end
         owed_results.push_back(r);
      endfunction

      // Compare one result beat against the oldest owed result
      function void check_result(logic [2:0] outcome, logic [BASE_W-1:0] base,
                                 logic [SIZE_W-1:0] cap);
         pool_result_type want;
         if (owed_results.size() == 0) begin
            $error("result beat with nothing owed: outcome %0d", outcome);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         tally[want.outcome]++;
         if (outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, outcome);
            errors++;
         end
         if (base !== want.base) begin
            $error("found_base: expected %h, got %h", want.base, base);
            errors++;
         end
         if (cap !== want.cap) begin
            $error("found_capacity: expected %h, got %h", want.cap, cap);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_type;
   logic [BASE_W-1:0]   req_block_base;
   logic [SIZE_W-1:0]   req_block_size;
   logic                rsp_strobe;
   logic [2:0]          rsp_outcome;
   logic [BASE_W-1:0]   rsp_found_base;
   logic [SIZE_W-1:0]   rsp_found_capacity;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   pool_scoreboard sb = new();
   int             idle_pct;
   int             csr_writes;

   retained_block_pool uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_block_base     (req_block_base),
      .req_block_size     (req_block_size),
      .rsp_strobe         (rsp_strobe),
      .rsp_outcome        (rsp_outcome),
      .rsp_found_base     (rsp_found_base),
      .rsp_found_capacity (rsp_found_capacity),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   initial begin
      #3ms;
      $display("Some tests failed");
      $finish;
   end

   // Monitor: results are checked before new requests are noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_result(rsp_outcome, rsp_found_base, rsp_found_capacity);
         if (start && !busy) sb.note_request(req_kind_type'(req_type), req_block_base,
                                             req_block_size);
      end
   end

   // Drive one request beat, with a random gap first, and wait for accept
   task automatic send(req_kind_type kind, logic [BASE_W-1:0] base, logic [SIZE_W-1:0] size);
      int gap;
      gap = 0;
      while (gap < 16 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= kind;
      req_block_base <= base;
      req_block_size <= size;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Stop sending and let every owed result drain, plus scan latency
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (POOL_ENTRIES + 2) @(posedge clock);
   endtask

   // APB write followed by a read-back of the same register
   task automatic csr_write(reg_index_type idx, logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_writes++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== value) begin
         $error("prdata: expected %h, got %h", value, prdata);
         sb.errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      // return to idle before the next transfer
      @(posedge clock);
   endtask

   function automatic logic [SIZE_W-1:0] rand_floor();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return $urandom();
         default: return SIZE_W'(1) << $urandom_range(20);
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] rand_budget();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return $urandom();
         default: return (SIZE_W'(1) << $urandom_range(12, 31)) | SIZE_W'($urandom_range(4095));
      endcase
   endfunction

   // Sizes cluster around the floor and the held blocks to hit the edges
   function automatic logic [SIZE_W-1:0] rand_size();
      logic [SIZE_W:0] span;
      logic [SIZE_W:0] wide;
      span = {1'b0, SIZE_W'($urandom())} >> $urandom_range(8, 31);
      wide = {1'b0, sb.min_size} + span;
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return sb.min_size + SIZE_W'($urandom_range(2)) - SIZE_W'(1);
         3, 4:    return sb.some_held_size() - SIZE_W'($urandom_range(2));
         5:       return $urandom();
         default: return wide[SIZE_W] ? '1 : wide[SIZE_W-1:0];
      endcase
   endfunction

   // Stimulus
   initial begin
      req_kind_type kind;
      int           give_pct;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_type       <= 1'b0;
      req_block_base <= '0;
      req_block_size <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      idle_pct       = 0;
      csr_writes     = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset floor and budget
      send(REQ_TAKE, '1, 32'd0);                                // under the floor
      send(REQ_TAKE, '0, 32'hFFFF_FFFF);                        // empty pool
      send(REQ_GIVE, '1, 32'd262143);                           // one under the floor
      send(REQ_GIVE, '1, 32'd262144);                           // exactly the floor
      send(REQ_GIVE, '0, 32'h0100_0000);
      send(REQ_GIVE, 48'h0000_1234_5678, 32'h0100_0000);        // over budget
      send(REQ_GIVE, 48'h0A0A_0000_0000, 32'd262144);           // same size as entry 0
      send(REQ_TAKE, '0, 32'd262144);                           // tie goes to lowest index
      send(REQ_GIVE, 48'h0000_0010_0000, 32'h0010_0000);
      send(REQ_GIVE, 48'h0000_0020_0000, 32'h0010_0000);
      send(REQ_GIVE, 48'h5555_5555_5555, 32'd262144);           // pool full
      send(REQ_TAKE, 48'hAAAA_AAAA_AAAA, 32'h0008_0000);        // best fit, not first fit

      // Floor at zero, budget wide open
      settle();
      csr_write(REG_MIN_RETAIN, '0);
      csr_write(REG_MAX_BYTES, '1);
      repeat (3) send(REQ_TAKE, '0, 32'd0);                     // empties smallest first
      send(REQ_GIVE, 48'h0000_0000_0040, 32'd0);                // zero-size block is kept
      send(REQ_TAKE, '0, 32'd0);
      send(REQ_GIVE, '1, '1);
      send(REQ_TAKE, '0, '1);
      send(REQ_GIVE, 48'h0000_0000_1000, 32'd100);

      // Floor raised above a held block's original floor
      settle();
      csr_write(REG_MIN_RETAIN, 32'd50);
      send(REQ_TAKE, '0, 32'd60);
      send(REQ_GIVE, 48'h0000_0000_2000, 32'd1000);
      send(REQ_GIVE, 48'h0000_0000_3000, 32'd2000);

      // Budget dropped under what is already held
      settle();
      csr_write(REG_MAX_BYTES, '0);
      send(REQ_GIVE, 48'h0000_0000_4000, 32'd50);
      send(REQ_TAKE, '0, 32'd1500);

      // Floor at its top
      settle();
      csr_write(REG_MIN_RETAIN, '1);
      send(REQ_GIVE, 48'h0000_0000_5000, 32'hFFFF_FFFE);
      send(REQ_TAKE, '0, 32'hFFFF_FFFE);

      // Random: nine settings, sender idle 23%, then 65%, then none
      for (int seg = 0; seg < 9; seg++) begin
         idle_pct = (seg < 3) ? 23 : ((seg < 6) ? 65 : 0);
         settle();
         csr_write(REG_MIN_RETAIN, rand_floor());
         csr_write(REG_MAX_BYTES, rand_budget());
         repeat (112) begin
            if ($urandom_range(63) == 0) settle();
            if (sb.held_count == 0) give_pct = 80;
            else if (sb.held_count >= POOL_ENTRIES) give_pct = 25;
            else give_pct = 50;
            kind = ($urandom_range(99) < give_pct) ? REQ_GIVE : REQ_TAKE;
            send(kind, BASE_W'({$urandom(), $urandom()}), rand_size());
         end
      end

      // Drain and wrap up
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (POOL_ENTRIES + 4) @(posedge clock);
      $display("Covered %0d requests and %0d register writes over floor/budget extremes",
               sb.requests, csr_writes);
      $display("Outcomes hit/below/nofit/retained/small/full: %0d/%0d/%0d/%0d/%0d/%0d",
               sb.tally[0], sb.tally[1], sb.tally[2], sb.tally[3], sb.tally[4], sb.tally[5]);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
